/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property templates for the vertical area-average downscaler checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VAAD_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("vaad: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define VAAD_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("vaad: next-cycle check failed");

`endif

/* design/vaad_pkg.sv */
// ----------------------------------------------------------------------------
// vaad_pkg
// Widths, register indexes and shared types of the vertical downscaler.
// ----------------------------------------------------------------------------
package vaad_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int HEIGHT_W   = 13;
	localparam int LWIDTH_W   = 11;

	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH  = 2'd2;

	// Pixel and result fields
	localparam int NCH       = 3;
	localparam int CH_W      = 8;
	localparam int IN_DATA_W = 32;
	localparam int ROW_W     = HEIGHT_W;
	localparam int POS_W     = 2 * HEIGHT_W;
	localparam int QUO_W     = CH_W;
	localparam int OUT_ROW_W = 12;
	localparam int OUT_COL_W = 10;
	localparam int OUT_DATA_W = 48;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* design/vaad_div.sv */
// ----------------------------------------------------------------------------
// vaad_div
// Three-lane restoring divider, one quotient bit per cycle, shared divisor.
// ----------------------------------------------------------------------------
module vaad_div import vaad_pkg::*; #(
	parameter int ACC_W = 20
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [NCH-1:0][ACC_W-1:0]       dividend,
	input  logic [ROW_W-1:0]                divisor,
	output div_stat_t                       stat,
	output logic [NCH-1:0][QUO_W-1:0]       quotient
);

	localparam int TRIAL_W = ROW_W + QUO_W - 1;
	localparam int CMP_W   = (TRIAL_W > ACC_W) ? TRIAL_W + 1 : ACC_W + 1;
	localparam int CNT_W   = $clog2(QUO_W);

	logic [NCH-1:0][ACC_W-1:0] rem_q;
	logic [NCH-1:0][QUO_W-1:0] quo_q;
	logic [TRIAL_W-1:0]        trial_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(QUO_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// The sum never exceeds 255 times the divisor, so eight quotient bits suffice.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q   <= dividend;
			quo_q   <= '0;
			trial_q <= {divisor, {(QUO_W-1){1'b0}}};
		end else if (busy_q) begin
			trial_q <= trial_q >> 1;
			for (int i = 0; i < NCH; i++) begin
				if (CMP_W'(rem_q[i]) >= CMP_W'(trial_q)) begin
					rem_q[i] <= ACC_W'(CMP_W'(rem_q[i]) - CMP_W'(trial_q));
					quo_q[i] <= {quo_q[i][QUO_W-2:0], 1'b1};
				end else begin
					quo_q[i] <= {quo_q[i][QUO_W-2:0], 1'b0};
				end
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

/* design/vertical_area_average_downscale_unit.sv */
// ----------------------------------------------------------------------------
// Channel   Direction  Transfer contents
// s_axis    in         one source pixel, raster order
// m_axis    out        one averaged pixel with row and column, tlast on frame end
// cfg       in         register index and value
//
// A pixel that completes no output row passes through accept and a line store
// read-modify-write; one that completes a row passes through accept, accumulate,
// the bit-per-cycle divider and output load. A configuration write holds the
// input off while the row boundaries reload. The line store is not cleared
// after reset: row 0 of every frame overwrites each column.
// A stalled output blocks the next completing pixel, and the input with it.
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
// vertical_area_average_downscale_unit
// Vertical area-averaging downscaler with a per-column line store of sums.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vertical_area_average_downscale_unit import vaad_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // pixel_word
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// chan0, chan1, chan2, out_row, out_column, two zero bits
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast,   // frame_end
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ACC_W = $clog2(MAX_HEIGHT * 255 + 1);
	localparam int MEM_W = NCH * ACC_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ACC  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;

	// Configuration and effective (clamped) values
	logic [HEIGHT_W-1:0] src_height_q;
	logic [HEIGHT_W-1:0] dest_height_q;
	logic [LWIDTH_W-1:0] line_width_q;
	logic [HEIGHT_W-1:0] eff_s;
	logic [HEIGHT_W-1:0] eff_d;
	logic [LWIDTH_W-1:0] eff_w;
	logic                cfg_hit;

	// Frame position
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] src_row_q;
	logic [ROW_W-1:0] dest_row_q;
	logic [POS_W-1:0] src_end_q;
	logic [POS_W-1:0] dest_end_q;

	logic [1:0] state_q;
	logic       in_xfer;
	logic       last_col;
	logic       last_row;
	logic       emit;
	logic [POS_W-1:0] src_start;

	// Per-pixel stage registers
	logic [NCH-1:0][CH_W-1:0] px_s1;
	logic [ROW_W-1:0]         wa_s1;
	logic [ROW_W-1:0]         wn_s1;
	logic                     emit_s1;
	logic                     first_s1;
	logic [COL_W-1:0]         col_s1;
	logic [ROW_W-1:0]         row_s1;
	logic                     fend_s1;

	// Line store
	logic [MEM_W-1:0] mem [MAX_WIDTH];
	logic [MEM_W-1:0] rd_data_s1;
	logic [MEM_W-1:0] wr_data;
	logic             wr_en;

	logic [NCH-1:0][ACC_W-1:0] acc;
	logic [NCH-1:0][ACC_W-1:0] carry;

	div_stat_t                 div_stat;
	logic                      div_start;
	logic [NCH-1:0][QUO_W-1:0] quo;

	logic out_load;
	logic out_free;

	always_comb begin
		if (src_height_q == '0)
			eff_s = HEIGHT_W'(1);
		else if (32'(src_height_q) > MAX_HEIGHT)
			eff_s = HEIGHT_W'(MAX_HEIGHT);
		else
			eff_s = src_height_q;

		if (dest_height_q == '0)
			eff_d = HEIGHT_W'(1);
		else if (dest_height_q > eff_s)
			eff_d = eff_s;
		else
			eff_d = dest_height_q;

		if (line_width_q == '0)
			eff_w = LWIDTH_W'(1);
		else if (32'(line_width_q) > MAX_WIDTH)
			eff_w = LWIDTH_W'(MAX_WIDTH);
		else
			eff_w = line_width_q;
	end

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index == REG_SRC_HEIGHT ||
		cfg_index == REG_DEST_HEIGHT || cfg_index == REG_LINE_WIDTH);

	// A zero source boundary marks the reload cycle after a restart.
	assign s_axis_tready = (state_q == ST_IDLE) && (src_end_q != '0);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	assign last_col  = (32'(col_q) == 32'(eff_w) - 32'd1);
	assign last_row  = (src_row_q >= eff_s - 1'b1);
	assign emit      = (src_end_q >= dest_end_q);
	assign src_start = src_end_q - POS_W'(eff_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_height_q  <= HEIGHT_W'(1);
			dest_height_q <= HEIGHT_W'(1);
			line_width_q  <= LWIDTH_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SRC_HEIGHT:  src_height_q  <= cfg_data[HEIGHT_W-1:0];
				REG_DEST_HEIGHT: dest_height_q <= cfg_data[HEIGHT_W-1:0];
				REG_LINE_WIDTH:  line_width_q  <= cfg_data[LWIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	// A write restarts the frame with the values it leaves behind, so the
	// boundaries come from the register contents of the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			src_row_q  <= '0;
			dest_row_q <= '0;
			src_end_q  <= POS_W'(1);
			dest_end_q <= POS_W'(1);
		end else if (cfg_hit) begin
			col_q      <= '0;
			src_row_q  <= '0;
			dest_row_q <= '0;
			src_end_q  <= '0;
			dest_end_q <= '0;
		end else if (in_xfer) begin
			if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					src_row_q  <= '0;
					dest_row_q <= '0;
					src_end_q  <= POS_W'(eff_d);
					dest_end_q <= POS_W'(eff_s);
				end else begin
					src_row_q <= src_row_q + 1'b1;
					src_end_q <= src_end_q + POS_W'(eff_d);
					if (emit) begin
						dest_row_q <= dest_row_q + 1'b1;
						dest_end_q <= dest_end_q + POS_W'(eff_s);
					end
				end
			end else begin
				col_q <= col_q + 1'b1;
			end
		end else if (src_end_q == '0) begin
			// First cycle after a restart by configuration: load boundaries.
			src_end_q  <= POS_W'(eff_d);
			dest_end_q <= POS_W'(eff_s);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			for (int k = 0; k < NCH; k++)
				px_s1[k] <= s_axis_tdata[k*CH_W +: CH_W];
			wa_s1    <= emit ? ROW_W'(dest_end_q - src_start) : eff_d;
			wn_s1    <= ROW_W'(src_end_q - dest_end_q);
			emit_s1  <= emit;
			first_s1 <= (src_row_q == '0);
			col_s1   <= col_q;
			row_s1   <= dest_row_q;
			fend_s1  <= last_col && (src_row_q == eff_s - 1'b1);
		end
	end

	// The next pixel is accepted only after the write-back, so a read never
	// overlaps a pending write to the same column.
	always_ff @(posedge clk) begin
		if (in_xfer)
			rd_data_s1 <= mem[col_q];
		if (wr_en)
			mem[col_s1] <= wr_data;
	end

	always_comb begin
		for (int k = 0; k < NCH; k++) begin
			acc[k] = (first_s1 ? '0 : rd_data_s1[k*ACC_W +: ACC_W])
				+ ACC_W'(px_s1[k]) * ACC_W'(wa_s1);
			carry[k] = ACC_W'(px_s1[k]) * ACC_W'(wn_s1);
			wr_data[k*ACC_W +: ACC_W] = emit_s1 ? carry[k] : acc[k];
		end
	end

	assign wr_en     = (state_q == ST_ACC);
	assign div_start = (state_q == ST_ACC) && emit_s1;

	vaad_div #(
		.ACC_W (ACC_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (acc),
		.divisor  (eff_s),
		.stat     (div_stat),
		.quotient (quo)
	);

	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign out_load = (state_q == ST_DIV) && div_stat.done && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_xfer) state_q <= ST_ACC;
				ST_ACC:  state_q <= emit_s1 ? ST_DIV : ST_IDLE;
				ST_DIV:  if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tvalid <= 1'b0;
		else if (out_load)
			m_axis_tvalid <= 1'b1;
		else if (m_axis_tready)
			m_axis_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_axis_tdata <= {2'b00, OUT_COL_W'(col_s1), OUT_ROW_W'(row_s1),
				quo[2], quo[1], quo[0]};
			m_axis_tlast <= fend_s1;
		end
	end

	`VAAD_ASSERT_IMP(a_col_in_range, clk, arst_n, 1'b1, 32'(col_q) < 32'(eff_w))
	`VAAD_ASSERT_NXT(a_accept_to_acc, clk, arst_n, in_xfer && !cfg_hit, state_q == ST_ACC)
	`VAAD_ASSERT_IMP(a_div_quiet_idle, clk, arst_n, state_q == ST_IDLE, !div_stat.busy)
	`VAAD_ASSERT_IMP(a_dest_behind_src, clk, arst_n, 1'b1, dest_row_q <= src_row_q)

endmodule
